### rtl/scsb_pkg.sv
// Package with the shared constants, types and state codes of the sparse cell set.
`default_nettype none

package scsb_pkg;

   localparam int CELL_W    = 15;
   localparam int CELL_CAP  = 1 << CELL_W;
   localparam int CNT_W     = 16;
   localparam int LOC_W     = 16;
   localparam int COORD_W   = 6;
   localparam int DIM_X_DEF = 32;
   localparam int DIM_Y_DEF = 32;
   localparam int DIM_Z_DEF = 32;

   localparam logic [LOC_W-1:0] LOC_ABSENT = {LOC_W{1'b1}};

   typedef enum logic {
      FUNC_ADD        = 1'b0,
      FUNC_REMOVE_BOX = 1'b1
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_CHK,
      ST_BOX_SETUP,
      ST_CELL_RD,
      ST_CELL_CHK,
      ST_CELL_MOVE,
      ST_CELL_DROP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      WALK_RUN,
      WALK_LOAD,
      WALK_BASE
   } walk_phase_type;

   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [LOC_W-1:0]  wdata;
      logic              re;
      logic [CELL_W-1:0] raddr;
   } loc_port_type;

   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic              re;
      logic [CELL_W-1:0] raddr;
   } dense_port_type;

   typedef struct packed {
      logic start;
      logic step;
   } walk_cmd_type;

   typedef struct packed {
      logic ready;
      logic empty;
      logic last;
      logic in_table;
   } walk_sts_type;

   typedef struct packed {
      logic [CELL_W-1:0] slot;
      logic [CNT_W-1:0]  removed;
      logic [CNT_W-1:0]  count;
      logic              rejected;
   } res_type;

endpackage

`default_nettype wire

### rtl/scsb_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
`default_nettype none

module scsb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/scsb_box_walk.sv
// Box walker that clamps the bounds and steps through the cell ids of the box.
`default_nettype none

module scsb_box_walk
   import scsb_pkg::*;
#(
   parameter int DIM_X = DIM_X_DEF,
   parameter int DIM_Y = DIM_Y_DEF,
   parameter int DIM_Z = DIM_Z_DEF,
   parameter int ID_W  = CELL_W + 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COORD_W-1:0] lo_x,
   input  wire logic [COORD_W-1:0] lo_y,
   input  wire logic [COORD_W-1:0] lo_z,
   input  wire logic [COORD_W-1:0] hi_x,
   input  wire logic [COORD_W-1:0] hi_y,
   input  wire logic [COORD_W-1:0] hi_z,
   input  wire walk_cmd_type       cmd,
   output      walk_sts_type       sts,
   output      logic [ID_W-1:0]    id
);

   localparam int CX_W = $clog2(DIM_X + 1);
   localparam int CY_W = $clog2(DIM_Y + 1);
   localparam int CZ_W = $clog2(DIM_Z + 1);
   localparam int T_W  = $clog2(DIM_X * DIM_Y + 1);

   walk_phase_type  phase_ff, phase_in;
   logic [CX_W-1:0] x0_ff, x1_ff, x_ff, x_in;
   logic [CY_W-1:0] y0_ff, y1_ff, y_ff, y_in;
   logic [CZ_W-1:0] z0_ff, z1_ff, z_ff, z_in;
   logic [T_W-1:0]  t_ff;
   logic [ID_W-1:0] plane_ff, plane_in, row_ff, row_in, id_ff, id_in;
   logic [CX_W-1:0] cx_lo, cx_hi, x_nx;
   logic [CY_W-1:0] cy_lo, cy_hi, y_nx;
   logic [CZ_W-1:0] cz_lo, cz_hi, z_nx;
   logic            z_end, y_end, x_end;

   assign cx_lo = (32'(lo_x) > DIM_X) ? CX_W'(DIM_X) : CX_W'(lo_x);
   assign cy_lo = (32'(lo_y) > DIM_Y) ? CY_W'(DIM_Y) : CY_W'(lo_y);
   assign cz_lo = (32'(lo_z) > DIM_Z) ? CZ_W'(DIM_Z) : CZ_W'(lo_z);
   assign cx_hi = (32'(hi_x) > DIM_X) ? CX_W'(DIM_X) : CX_W'(hi_x);
   assign cy_hi = (32'(hi_y) > DIM_Y) ? CY_W'(DIM_Y) : CY_W'(hi_y);
   assign cz_hi = (32'(hi_z) > DIM_Z) ? CZ_W'(DIM_Z) : CZ_W'(hi_z);

   assign x_nx  = x_ff + 1'b1;
   assign y_nx  = y_ff + 1'b1;
   assign z_nx  = z_ff + 1'b1;
   assign x_end = (x_nx == x1_ff);
   assign y_end = (y_nx == y1_ff);
   assign z_end = (z_nx == z1_ff);

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         WALK_LOAD: phase_in = WALK_BASE;
         WALK_BASE: phase_in = WALK_RUN;
         default:   phase_in = phase_ff;
      endcase
      if (cmd.start) begin
         phase_in = WALK_LOAD;
      end
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      plane_in = plane_ff;
      row_in   = row_ff;
      id_in    = id_ff;
      case (phase_ff)
         WALK_LOAD: begin
            x_in = x0_ff;
            y_in = y0_ff;
            z_in = z0_ff;
         end
         WALK_BASE: begin
            plane_in = ID_W'(32'(t_ff) * DIM_Z + 32'(z0_ff));
            row_in   = plane_in;
            id_in    = plane_in;
         end
         default: begin
            if (cmd.step) begin
               if (!z_end) begin
                  z_in  = z_nx;
                  id_in = id_ff + 1'b1;
               end else if (!y_end) begin
                  y_in   = y_nx;
                  z_in   = z0_ff;
                  row_in = row_ff + ID_W'(DIM_Z);
                  id_in  = row_in;
               end else begin
                  x_in     = x_nx;
                  y_in     = y0_ff;
                  z_in     = z0_ff;
                  plane_in = plane_ff + ID_W'(DIM_Y * DIM_Z);
                  row_in   = plane_in;
                  id_in    = plane_in;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= WALK_RUN;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x0_ff <= cx_lo;
         y0_ff <= cy_lo;
         z0_ff <= cz_lo;
         x1_ff <= cx_hi;
         y1_ff <= cy_hi;
         z1_ff <= cz_hi;
      end
      if (phase_ff == WALK_LOAD) begin
         t_ff <= T_W'(32'(x0_ff) * DIM_Y + 32'(y0_ff));
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      plane_ff <= plane_in;
      row_ff   <= row_in;
      id_ff    <= id_in;
   end

   assign sts.ready    = (phase_ff == WALK_RUN);
   assign sts.empty    = (x0_ff >= x1_ff) || (y0_ff >= y1_ff) || (z0_ff >= z1_ff);
   assign sts.last     = x_end && y_end && z_end;
   assign sts.in_table = (32'(id_ff) < CELL_CAP);
   assign id           = id_ff;

endmodule

`default_nettype wire

### rtl/scsb_ctrl.sv
// Sequencer that clears the location memory and runs the add and remove-box updates.
`default_nettype none

module scsb_ctrl
   import scsb_pkg::*;
#(
   parameter int ID_W = CELL_W + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_func,
   input  wire logic [CELL_W-1:0] req_cell_id,
   output      logic              req_ready,
   output      walk_cmd_type      walk_cmd,
   input  wire walk_sts_type      walk_sts,
   input  wire logic [ID_W-1:0]   walk_id,
   output      loc_port_type      loc_port,
   input  wire logic [LOC_W-1:0]  loc_rdata,
   output      dense_port_type    dense_port,
   input  wire logic [CELL_W-1:0] dense_rdata,
   input  wire logic              rsp_free,
   output      logic              done,
   output      res_type           result
);

   state_type         state_ff, state_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic [CELL_W-1:0] id_ff, id_in;
   logic [CELL_W-1:0] loc_ff, loc_in;
   logic [CELL_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  removed_ff, removed_in;
   logic              rej_ff, rej_in;
   logic [CNT_W-1:0]  count_m1;
   logic              present;

   assign count_m1 = count_ff - 1'b1;
   assign present  = (loc_rdata != LOC_ABSENT) && (count_ff != '0) && (loc_rdata < count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_REMOVE_BOX) ? ST_BOX_SETUP : ST_ADD_CHK;
            end
         end
         ST_ADD_CHK: state_in = ST_DONE;
         ST_BOX_SETUP: begin
            if (walk_sts.ready) begin
               state_in = walk_sts.empty ? ST_DONE : ST_CELL_RD;
            end
         end
         ST_CELL_RD: begin
            if (walk_sts.in_table) begin
               state_in = ST_CELL_CHK;
            end else if (walk_sts.last) begin
               state_in = ST_DONE;
            end
         end
         ST_CELL_CHK: begin
            if (present) begin
               state_in = ST_CELL_MOVE;
            end else begin
               state_in = walk_sts.last ? ST_DONE : ST_CELL_RD;
            end
         end
         ST_CELL_MOVE: state_in = ST_CELL_DROP;
         ST_CELL_DROP: state_in = walk_sts.last ? ST_DONE : ST_CELL_RD;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      walk_cmd   = '0;
      loc_port   = '0;
      dense_port = '0;
      done       = 1'b0;
      clr_in     = clr_ff;
      id_in      = id_ff;
      loc_in     = loc_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      rej_in     = rej_ff;
      case (state_ff)
         ST_CLEAR: begin
            loc_port.we    = 1'b1;
            loc_port.waddr = clr_ff;
            loc_port.wdata = LOC_ABSENT;
            clr_in         = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               loc_port.re    = 1'b1;
               loc_port.raddr = req_cell_id;
               id_in          = req_cell_id;
               slot_in        = '0;
               removed_in     = '0;
               rej_in         = 1'b0;
               walk_cmd.start = (req_func == FUNC_REMOVE_BOX);
            end
         end
         ST_ADD_CHK: begin
            if ((loc_rdata != LOC_ABSENT) || (count_ff >= CNT_W'(CELL_CAP))) begin
               rej_in = 1'b1;
            end else begin
               loc_port.we      = 1'b1;
               loc_port.waddr   = id_ff;
               loc_port.wdata   = LOC_W'(count_ff);
               dense_port.we    = 1'b1;
               dense_port.waddr = count_ff[CELL_W-1:0];
               dense_port.wdata = id_ff;
               slot_in          = count_ff[CELL_W-1:0];
               count_in         = count_ff + 1'b1;
            end
         end
         ST_BOX_SETUP: begin
         end
         ST_CELL_RD: begin
            if (walk_sts.in_table) begin
               loc_port.re    = 1'b1;
               loc_port.raddr = walk_id[CELL_W-1:0];
            end else begin
               walk_cmd.step = !walk_sts.last;
            end
         end
         ST_CELL_CHK: begin
            if (present) begin
               dense_port.re    = 1'b1;
               dense_port.raddr = count_m1[CELL_W-1:0];
               loc_in           = loc_rdata[CELL_W-1:0];
            end else begin
               walk_cmd.step = !walk_sts.last;
            end
         end
         ST_CELL_MOVE: begin
            loc_port.we      = 1'b1;
            loc_port.waddr   = dense_rdata;
            loc_port.wdata   = LOC_W'(loc_ff);
            dense_port.we    = 1'b1;
            dense_port.waddr = loc_ff;
            dense_port.wdata = dense_rdata;
         end
         ST_CELL_DROP: begin
            loc_port.we    = 1'b1;
            loc_port.waddr = walk_id[CELL_W-1:0];
            loc_port.wdata = LOC_ABSENT;
            count_in       = count_m1;
            removed_in     = removed_ff + 1'b1;
            walk_cmd.step  = !walk_sts.last;
         end
         ST_DONE: begin
            done = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      loc_ff     <= loc_in;
      slot_ff    <= slot_in;
      removed_ff <= removed_in;
      rej_ff     <= rej_in;
   end

   assign result.slot     = slot_ff;
   assign result.removed  = removed_ff;
   assign result.count    = count_ff;
   assign result.rejected = rej_ff;

endmodule

`default_nettype wire

### rtl/sparse_cell_set_box_remove.sv
// An add checks the location entry of its cell and then gives its result beat.
// A remove-box sets up the box walk and visits each cell of the box in turn: an
// in-grid cell is read and checked, and if present also moved and dropped; a cell
// beyond the location memory is stepped over. One item is in work at a time; a new
// request beat is taken only once the last result is registered. After reset a clearing
// pass marks all 32768 location entries absent, one per cycle, while req_tready is low.
`default_nettype none

module sparse_cell_set_box_remove
   import scsb_pkg::*;
#(
   parameter int DIM_X = DIM_X_DEF,
   parameter int DIM_Y = DIM_Y_DEF,
   parameter int DIM_Z = DIM_Z_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // cell_id, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, zero fill
   input  wire logic [55:0] req_tdata,
   // func
   input  wire logic [0:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // slot_written, removed_count, entry_count, zero fill
   output      logic [47:0] rsp_tdata,
   // rejected
   output      logic [0:0]  rsp_tuser
);

   localparam int PROD_W = $clog2(DIM_X * DIM_Y * DIM_Z) + 1;
   localparam int ID_W   = (PROD_W > CELL_W + 1) ? PROD_W : CELL_W + 1;

   walk_cmd_type      walk_cmd;
   walk_sts_type      walk_sts;
   logic [ID_W-1:0]   walk_id;
   loc_port_type      loc_port;
   dense_port_type    dense_port;
   logic [LOC_W-1:0]  loc_rdata;
   logic [CELL_W-1:0] dense_rdata;
   logic              done;
   res_type           result;
   logic              rsp_free;
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_ff;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   scsb_ctrl #(
      .ID_W (ID_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_func    (req_tuser[0]),
      .req_cell_id (req_tdata[14:0]),
      .req_ready   (req_tready),
      .walk_cmd    (walk_cmd),
      .walk_sts    (walk_sts),
      .walk_id     (walk_id),
      .loc_port    (loc_port),
      .loc_rdata   (loc_rdata),
      .dense_port  (dense_port),
      .dense_rdata (dense_rdata),
      .rsp_free    (rsp_free),
      .done        (done),
      .result      (result)
   );

   scsb_box_walk #(
      .DIM_X (DIM_X),
      .DIM_Y (DIM_Y),
      .DIM_Z (DIM_Z),
      .ID_W  (ID_W)
   ) u_walk (
      .clock (clock),
      .reset (reset),
      .lo_x  (req_tdata[20:15]),
      .lo_y  (req_tdata[26:21]),
      .lo_z  (req_tdata[32:27]),
      .hi_x  (req_tdata[38:33]),
      .hi_y  (req_tdata[44:39]),
      .hi_z  (req_tdata[50:45]),
      .cmd   (walk_cmd),
      .sts   (walk_sts),
      .id    (walk_id)
   );

   scsb_ram #(
      .WIDTH (LOC_W),
      .DEPTH (CELL_CAP)
   ) u_loc_ram (
      .clock (clock),
      .we    (loc_port.we),
      .waddr (loc_port.waddr),
      .wdata (loc_port.wdata),
      .re    (loc_port.re),
      .raddr (loc_port.raddr),
      .rdata (loc_rdata)
   );

   scsb_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_CAP)
   ) u_dense_ram (
      .clock (clock),
      .we    (dense_port.we),
      .waddr (dense_port.waddr),
      .wdata (dense_port.wdata),
      .re    (dense_port.re),
      .raddr (dense_port.raddr),
      .rdata (dense_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {1'b0, rsp_ff.count, rsp_ff.removed, rsp_ff.slot};
   assign rsp_tuser[0] = rsp_ff.rejected;

endmodule

`default_nettype wire

### rtl/scsb_checker.sv
// Port-level checker for the sparse cell set, bound to the top level.
`default_nettype none

module scsb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [55:0] req_tdata,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // The clearing pass keeps the request side closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request side open during the clearing pass");

   // Only one item is in work at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item is still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

   // A rejected add reports neither a slot nor removed cells.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[30:0] == 31'd0))
      else $error("rejected add reports a slot or removed cells");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[46:31] <= 16'd32768))
      else $error("entry count beyond capacity");

endmodule

bind sparse_cell_set_box_remove scsb_checker u_scsb_checker (.*);

`default_nettype wire
